// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL of the JSON string unescape core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define JSU_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Clocked implication, disabled while reset is asserted.
`define JSU_ASSERT_IMPL(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("%m: implication failed");

`endif

// ===== rtl/core/jsu_pkg.sv =====
// Types, codes and helper functions for the JSON string unescape core.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  // Decoder modes
  localparam logic [2:0] MODE_TEXT    = 3'd0;
  localparam logic [2:0] MODE_ESC     = 3'd1;
  localparam logic [2:0] MODE_HEX     = 3'd2;
  localparam logic [2:0] MODE_HI_BS   = 3'd3;  // high surrogate held, want backslash
  localparam logic [2:0] MODE_HI_U    = 3'd4;  // high surrogate held, want u
  localparam logic [2:0] MODE_LO_HEX  = 3'd5;

  // Characters with special meaning
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6e;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  localparam logic [15:0] SURR_HI_BASE = 16'hd800;
  localparam logic [15:0] SURR_LO_BASE = 16'hdc00;
  localparam logic [15:0] SURR_END     = 16'he000;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);
  localparam int unsigned IdxW       = $clog2(MaxResults);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_req;
  } jsu_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_string;
    logic       bad_escape;
    logic       last;
  } jsu_out_t;

  // All results caused by one input byte
  typedef struct packed {
    logic [CntW-1:0]                 count;
    jsu_out_t [MaxResults-1:0]       res;
  } jsu_bundle_t;

  function automatic jsu_out_t mk_byte(logic [7:0] b);
    jsu_out_t r;
    r            = '0;
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    return r;
  endfunction

  function automatic jsu_out_t mk_end();
    jsu_out_t r;
    r               = '0;
    r.end_of_string = 1'b1;
    return r;
  endfunction

  function automatic jsu_out_t mk_bad();
    jsu_out_t r;
    r            = '0;
    r.bad_escape = 1'b1;
    return r;
  endfunction

  // {ok, value}
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  // {known, mapped byte} for a single-letter escape
  function automatic logic [8:0] esc_map(logic [7:0] c);
    logic [8:0] r;
    case (c)
      CH_QUOTE:  r = {1'b1, CH_QUOTE};
      CH_BSLASH: r = {1'b1, CH_BSLASH};
      CH_SLASH:  r = {1'b1, CH_SLASH};
      CH_LOW_B:  r = {1'b1, 8'h08};
      CH_LOW_F:  r = {1'b1, 8'h0c};
      CH_LOW_N:  r = {1'b1, 8'h0a};
      CH_LOW_R:  r = {1'b1, 8'h0d};
      CH_LOW_T:  r = {1'b1, 8'h09};
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/jsu_decode.sv =====
// Decoder state and the single-pass decode of one byte into its result bundle.
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode
  import jsu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  jsu_in_t     item_i,
  input  logic        advance_i,
  output jsu_bundle_t bundle_o
);

  logic [2:0]  mode_q, mode_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  dc_q, dc_d;
  logic [9:0]  pend_q, pend_d;

  logic [2:0]  mode_e;
  logic [15:0] acc_e;
  logic [1:0]  dc_e;
  logic [9:0]  pend_e;

  logic [7:0]  c;
  logic [4:0]  hex;
  logic [8:0]  esc;
  logic [15:0] acc_n;
  logic [15:0] hi_cp;
  logic [20:0] sup_cp;
  jsu_out_t [MaxResults-1:0] res;
  logic [CntW-1:0] cnt;

  assign c      = item_i.in_byte;
  assign mode_e = item_i.start_req ? MODE_TEXT : mode_q;
  assign acc_e  = item_i.start_req ? '0 : acc_q;
  assign dc_e   = item_i.start_req ? '0 : dc_q;
  assign pend_e = item_i.start_req ? '0 : pend_q;

  assign hex    = hex_digit(c);
  assign esc    = esc_map(c);
  assign acc_n  = {acc_e[11:0], hex[3:0]};
  assign hi_cp  = SURR_HI_BASE | {6'd0, pend_e};
  assign sup_cp = SUPP_BASE + {1'b0, pend_e, acc_n[9:0]};

  always_comb begin
    mode_d = mode_e;
    acc_d  = acc_e;
    dc_d   = dc_e;
    pend_d = pend_e;
    res    = '0;
    cnt    = '0;
    case (mode_e)
      MODE_ESC: begin
        mode_d = MODE_TEXT;
        if (c == CH_LOW_U) begin
          mode_d = MODE_HEX;
          acc_d  = '0;
          dc_d   = '0;
        end else begin
          res[0] = esc[8] ? mk_byte(esc[7:0]) : mk_bad();
          cnt    = CntW'(1);
        end
      end
      MODE_HEX, MODE_LO_HEX: begin
        if (!hex[4]) begin
          res[0] = mk_bad();
          cnt    = CntW'(1);
          mode_d = MODE_TEXT;
          acc_d  = '0;
          dc_d   = '0;
          pend_d = '0;
        end else if (dc_e != 2'd3) begin
          acc_d = acc_n;
          dc_d  = 2'(dc_e + 2'd1);
        end else if (mode_e == MODE_HEX) begin
          acc_d = '0;
          dc_d  = '0;
          if (acc_n >= SURR_HI_BASE && acc_n < SURR_LO_BASE) begin
            pend_d = acc_n[9:0];
            mode_d = MODE_HI_BS;
          end else begin
            mode_d = MODE_TEXT;
            if (acc_n < 16'h0080) begin
              res[0] = mk_byte(acc_n[7:0]);
              cnt    = CntW'(1);
            end else if (acc_n < 16'h0800) begin
              res[0] = mk_byte({3'b110, acc_n[10:6]});
              res[1] = mk_byte({2'b10, acc_n[5:0]});
              cnt    = CntW'(2);
            end else begin
              res[0] = mk_byte({4'b1110, acc_n[15:12]});
              res[1] = mk_byte({2'b10, acc_n[11:6]});
              res[2] = mk_byte({2'b10, acc_n[5:0]});
              cnt    = CntW'(3);
            end
          end
        end else begin
          // second \u complete: pair up or send the high surrogate alone
          if (acc_n >= SURR_LO_BASE && acc_n < SURR_END) begin
            res[0] = mk_byte({5'b11110, sup_cp[20:18]});
            res[1] = mk_byte({2'b10, sup_cp[17:12]});
            res[2] = mk_byte({2'b10, sup_cp[11:6]});
            res[3] = mk_byte({2'b10, sup_cp[5:0]});
            cnt    = CntW'(4);
          end else begin
            res[0] = mk_byte({4'b1110, hi_cp[15:12]});
            res[1] = mk_byte({2'b10, hi_cp[11:6]});
            res[2] = mk_byte({2'b10, hi_cp[5:0]});
            cnt    = CntW'(3);
          end
          mode_d = MODE_TEXT;
          acc_d  = '0;
          dc_d   = '0;
          pend_d = '0;
        end
      end
      MODE_HI_BS, MODE_HI_U: begin
        if ((mode_e == MODE_HI_BS && c == CH_BSLASH) ||
            (mode_e == MODE_HI_U && c == CH_LOW_U)) begin
          if (mode_e == MODE_HI_BS) begin
            mode_d = MODE_HI_U;
          end else begin
            mode_d = MODE_LO_HEX;
            acc_d  = '0;
            dc_d   = '0;
          end
        end else begin
          // lone high surrogate, then the held byte as usual
          res[0] = mk_byte({4'b1110, hi_cp[15:12]});
          res[1] = mk_byte({2'b10, hi_cp[11:6]});
          res[2] = mk_byte({2'b10, hi_cp[5:0]});
          cnt    = CntW'(4);
          pend_d = '0;
          mode_d = MODE_TEXT;
          if (mode_e == MODE_HI_U) begin
            res[3] = esc[8] ? mk_byte(esc[7:0]) : mk_bad();
          end else if (c == CH_QUOTE) begin
            res[3] = mk_end();
            acc_d  = '0;
            dc_d   = '0;
          end else begin
            res[3] = mk_byte(c);
          end
        end
      end
      default: begin
        if (c == CH_QUOTE) begin
          res[0] = mk_end();
          cnt    = CntW'(1);
          mode_d = MODE_TEXT;
          acc_d  = '0;
          dc_d   = '0;
          pend_d = '0;
        end else if (c == CH_BSLASH) begin
          mode_d = MODE_ESC;
        end else begin
          res[0] = mk_byte(c);
          cnt    = CntW'(1);
          mode_d = MODE_TEXT;
        end
      end
    endcase
  end

  assign bundle_o.count = cnt;
  assign bundle_o.res   = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_TEXT;
      acc_q  <= '0;
      dc_q   <= '0;
      pend_q <= '0;
    end else if (advance_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      dc_q   <= dc_d;
      pend_q <= pend_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/jsu_serializer.sv =====
// Result register holding one byte's results and sending them one per transfer.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module jsu_serializer
  import jsu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  jsu_bundle_t bundle_i,
  output logic        load_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output jsu_out_t    out_data_o
);

  jsu_bundle_t     bun_q;
  logic            vld_q;
  logic [IdxW-1:0] idx_q;
  logic            is_last;
  logic            xfer;

  assign is_last      = ({1'b0, idx_q} == CntW'(bun_q.count - CntW'(1)));
  assign xfer         = vld_q && out_ready_i;
  assign load_ready_o = !vld_q || (xfer && is_last);
  assign out_valid_o  = vld_q;

  always_comb begin
    out_data_o      = bun_q.res[idx_q];
    out_data_o.last = is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (load_i && load_ready_o) begin
      vld_q <= 1'b1;
      idx_q <= '0;
    end else if (xfer) begin
      if (is_last) begin
        vld_q <= 1'b0;
      end else begin
        idx_q <= IdxW'(idx_q + IdxW'(1));
      end
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (load_i && load_ready_o) begin
      bun_q <= bundle_i;
    end
  end

  `JSU_ASSERT_IMPL(a_count_range, clk_i, rst_ni, vld_q,
                   bun_q.count != '0 && bun_q.count <= CntW'(MaxResults))
  `JSU_ASSERT_IMPL(a_idx_in_bundle, clk_i, rst_ni, vld_q,
                   {1'b0, idx_q} < bun_q.count)
  `JSU_ASSERT(a_idx_steps, clk_i, rst_ni,
              (xfer && !is_last && !load_i) |=>
                (vld_q && idx_q == IdxW'($past(idx_q) + IdxW'(1))))

endmodule

`default_nettype wire

// ===== rtl/core/json_string_unescape_core.sv =====
// Top level of the streaming JSON string unescape core.
//
// Usage: feed the bytes of a JSON string body, starting after the opening
// quote, on the in channel (valid/ready, payload in_data_i). Set start_req
// on the first byte of each string to drop any pending escape state.
// Results leave on the out channel (valid/ready, payload out_data_o): one
// decoded UTF-8 byte, an end-of-string mark or a bad-escape mark per
// transfer, with last set on the final result caused by an input byte.
// A byte may cause no result (backslash, early hex digits, surrogate
// lookahead) or up to four.
// A byte taken into the input register is decoded combinationally, and
// its results are registered in the result register before they transfer.
// Throughput: one input byte per cycle while out_ready_i is high and each
// byte yields at most one result; a byte with k results holds the output
// register for k transfers and the input stalls until its last one leaves.
// Reset clears the decoder state to text mode and empties both registers.
// When the receiver stalls, the current result holds, bytes with no result
// still pass, and in_ready_o drops once a byte with results waits.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_core
  import jsu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  jsu_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output jsu_out_t out_data_o
);

  jsu_in_t     in_q;
  logic        in_vld_q;
  logic        advance;
  logic        load_ready;
  jsu_bundle_t bundle;

  // a byte with no results never needs the result register
  assign advance    = in_vld_q && (bundle.count == '0 || load_ready);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  jsu_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (in_q),
    .advance_i (advance),
    .bundle_o  (bundle)
  );

  jsu_serializer u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance && bundle.count != '0),
    .bundle_i     (bundle),
    .load_ready_o (load_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire
